/* hw/rtl/assert_macros.svh */
// assertion macros shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// clocked property, held off while reset is asserted
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// clocked property, checked during reset as well
`define ASSERT_CLK_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst_n, prop, msg)
`define ASSERT_CLK_ALWAYS(label, clk, prop, msg)
`endif
`endif

/* hw/rtl/svst_pkg.sv */
// shared types and constants for the small value set table
package svst_pkg;

  // default number of entry cells
  localparam int unsigned SVST_CAPACITY = 16;

  localparam int unsigned OP_W     = 2;
  localparam int unsigned VAL_W    = 32;
  localparam int unsigned STAT_W   = 2;
  localparam int unsigned OUT_IDX_W = 5;

  typedef logic [OP_W-1:0]   opcode_t;
  typedef logic [VAL_W-1:0]  value_t;
  typedef logic [STAT_W-1:0] status_t;

  // operation codes
  localparam opcode_t OP_INSERT = 2'd0;
  localparam opcode_t OP_DELETE = 2'd1;
  localparam opcode_t OP_LOOKUP = 2'd2;

  // result status codes
  localparam status_t STAT_DONE   = 2'd0;
  localparam status_t STAT_DUP    = 2'd1;
  localparam status_t STAT_FULL   = 2'd2;
  localparam status_t STAT_ABSENT = 2'd3;

  // sequencer states
  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_UPD  = 2'b10
  } state_t;

  // per-cell control from the sequencer
  typedef struct packed {
    logic cmp_en;  // capture compare result this cycle
    logic valid;   // cell lies below the fill count
    logic load;    // write the incoming value
    logic shift;   // take the upper neighbour's entry
  } cell_ctl_t;

endpackage

/* hw/rtl/small_value_set_table.sv */
// top level of the small value set table
// A set of up to CAPACITY distinct 32-bit values kept in insertion order, one
// value per cell in a row of cells. In the cycle a transaction is accepted,
// every occupied cell compares its entry with the value and keeps a match
// flag; then, in the update state, the lowest match is picked and
// the row is updated (insert writes the cell at the fill count, delete has
// every cell from the match upward take its upper neighbour's entry). The
// result sits in an output register, so a new transaction is accepted while
// the previous result still waits; the update cycle stalls only if that
// register is still full. The next transaction waits for that update.
// No clearing pass after reset: cells are only read below the fill count.
`include "assert_macros.svh"

module small_value_set_table
  import svst_pkg::*;
#(
  parameter int unsigned CAPACITY = SVST_CAPACITY
) (
  input  logic        clk,
  input  logic        rst_n,
  // input transactions
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] value
  input  logic [1:0]  in_tuser,   // [1:0] opcode
  // result transactions
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata   // [1:0] status, [2] found, [7:3] position,
                                  // [12:8] count, [15:13] zero
);

  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  state_t            state_r, state_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  opcode_t           op_r, op_nxt;
  value_t            value_r, value_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [15:0]       out_data_r, out_data_nxt;

  logic              in_go;
  logic              upd_go;
  logic              ins_go;
  logic              del_go;
  logic              full;
  logic              any_hit;
  logic [IW-1:0]     first_idx;
  logic [CW-1:0]     pos;
  status_t           status;
  logic [CAPACITY-1:0] hits;
  logic [CAPACITY-1:0] at_or_above;
  value_t            entries [CAPACITY];
  cell_ctl_t         ctl [CAPACITY];

  assign in_go     = in_tvalid && in_tready;
  assign in_tready = (state_r == S_IDLE);
  assign upd_go    = (state_r == S_UPD) && (!out_valid_r || out_tready);
  assign full      = (cnt_r == CW'(CAPACITY));

  // row of entry cells
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    value_t nb;
    if (i == CAPACITY - 1) begin : g_top
      assign nb = entries[i];
    end else begin : g_mid
      assign nb = entries[i+1];
    end

    assign ctl[i].cmp_en = in_go;
    assign ctl[i].valid  = (CW'(i) < cnt_r);
    assign ctl[i].load   = ins_go && (cnt_r == CW'(i));
    assign ctl[i].shift  = del_go && at_or_above[i];

    svst_cell u_cell (
      .clk        (clk),
      .ctl        (ctl[i]),
      .cmp_value  (in_tdata),
      .load_value (value_r),
      .next_entry (nb),
      .entry      (entries[i]),
      .hit        (hits[i])
    );
  end

  svst_first_match #(
    .N  (CAPACITY),
    .IW (IW)
  ) u_first (
    .hits        (hits),
    .any_hit     (any_hit),
    .first_idx   (first_idx),
    .at_or_above (at_or_above)
  );

  assign pos = any_hit ? CW'(first_idx) : cnt_r;

  // operation decode and status
  always_comb begin
    ins_go  = 1'b0;
    del_go  = 1'b0;
    status  = STAT_DONE;
    cnt_nxt = cnt_r;
    case (op_r)
      OP_INSERT: begin
        if (any_hit) begin
          status = STAT_DUP;
        end else if (full) begin
          status = STAT_FULL;
        end else begin
          ins_go  = upd_go;
          cnt_nxt = upd_go ? cnt_r + CW'(1) : cnt_r;
        end
      end
      OP_DELETE: begin
        if (!any_hit) begin
          status = STAT_ABSENT;
        end else begin
          del_go  = upd_go;
          cnt_nxt = upd_go ? cnt_r - CW'(1) : cnt_r;
        end
      end
      default: begin
        status = STAT_DONE;
      end
    endcase
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_go) begin
          state_nxt = S_UPD;
        end
      end
      S_UPD: begin
        if (upd_go) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // captured transaction
  always_comb begin
    op_nxt    = op_r;
    value_nxt = value_r;
    if (in_go) begin
      op_nxt    = in_tuser;
      value_nxt = in_tdata;
    end
  end

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (upd_go) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = {3'b000, OUT_IDX_W'(cnt_nxt), OUT_IDX_W'(pos), any_hit, status};
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    value_r    <= value_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // checks
  `ASSERT_CLK(a_cnt_bound, clk, rst_n, cnt_r <= CW'(CAPACITY), "fill count above capacity")
  `ASSERT_CLK(a_accept_to_upd, clk, rst_n, in_go |=> (state_r == S_UPD), "no update after accept")
  `ASSERT_CLK(a_reject_keeps_cnt, clk, rst_n, (upd_go && (status != STAT_DONE)) |=> $stable(cnt_r), "count changed on rejected operation")
  `ASSERT_CLK(a_one_change, clk, rst_n, !(ins_go && del_go), "insert and delete together")

endmodule

/* hw/rtl/svst_cell.sv */
// one entry cell: stored value, equality compare and shift from neighbour
module svst_cell
  import svst_pkg::*;
(
  input  logic      clk,
  input  cell_ctl_t ctl,
  input  value_t    cmp_value,   // value of the incoming transaction
  input  value_t    load_value,  // value to write on insert
  input  value_t    next_entry,  // entry of the upper neighbour
  output value_t    entry,
  output logic      hit
);

  value_t entry_r;
  value_t entry_nxt;
  logic   hit_r;
  logic   hit_nxt;

  // entry update: insert writes, delete pulls down from the neighbour
  always_comb begin
    entry_nxt = entry_r;
    if (ctl.load) begin
      entry_nxt = load_value;
    end else if (ctl.shift) begin
      entry_nxt = next_entry;
    end
  end

  // match flag, only for occupied cells
  always_comb begin
    hit_nxt = hit_r;
    if (ctl.cmp_en) begin
      hit_nxt = ctl.valid && (entry_r == cmp_value);
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
    hit_r   <= hit_nxt;
  end

  assign entry = entry_r;
  assign hit   = hit_r;

endmodule

/* hw/rtl/svst_first_match.sv */
// picks the lowest matching cell and the mask of cells at or above it
module svst_first_match
  import svst_pkg::*;
#(
  parameter int unsigned N  = SVST_CAPACITY,
  parameter int unsigned IW = (N > 1) ? $clog2(N) : 1
) (
  input  logic [N-1:0]  hits,
  output logic          any_hit,
  output logic [IW-1:0] first_idx,
  output logic [N-1:0]  at_or_above
);

  logic [N-1:0] neg_hits;
  logic [N-1:0] first_oh;

  // lowest set bit and everything from it upward, via one negate
  assign neg_hits    = -hits;
  assign first_oh    = hits & neg_hits;
  assign at_or_above = hits | neg_hits;
  assign any_hit     = |hits;

  // one-hot to index
  always_comb begin
    first_idx = '0;
    for (int unsigned i = 0; i < N; i++) begin
      if (first_oh[i]) begin
        first_idx = first_idx | IW'(i);
      end
    end
  end

endmodule
